@@ sv/irbw_pkg.sv @@
// Shared constants, types and helper functions for the bilinear image resampler.
// Used by every module of the block; depends on nothing.
package irbw_pkg;

   // field and register widths
   localparam int COORD_W = 12;
   localparam int PIX_W = 32;
   localparam int CH_W = 8;
   localparam int SRC_CFG_W = 9;
   localparam int DST_W = 13;
   localparam int CNT_W = 3;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 13;

   // sizing
   localparam int MAX_SRC_WIDTH = 256;
   localparam int MAX_SRC_HEIGHT = 256;
   localparam int MAX_CHANNELS = 4;
   localparam int FRAC_BITS = 16;
   localparam int DST_LIMIT = 4096;
   localparam int PIX_CH = PIX_W / CH_W;
   localparam int LANES = (MAX_CHANNELS < PIX_CH) ? MAX_CHANNELS : PIX_CH;

   localparam int SZ_MAX = (MAX_SRC_WIDTH > MAX_SRC_HEIGHT) ? MAX_SRC_WIDTH : MAX_SRC_HEIGHT;
   localparam int SZ_W = $clog2(SZ_MAX + 1);
   localparam int DEPTH = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
   localparam int ADDR_W = $clog2(DEPTH);

   // position pipeline: product bits, dividend bits with fraction, total stages
   localparam int P_W = COORD_W + SZ_W;
   localparam int N_W = P_W + FRAC_BITS;
   localparam int LOC_LAT = 1 + N_W + P_W;

   // blend weights hold 0..ONE inclusive
   localparam int W_W = FRAC_BITS + 1;
   localparam logic [W_W-1:0] FIX_ONE = W_W'(1) << FRAC_BITS;
   localparam int LANE_LAT = 4;
   localparam int TAPS = 4;

   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_REQUEST = 1'b1
   } op_type;

   localparam logic [CSR_IDX_W-1:0] CSR_SRC_WIDTH = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SRC_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DST_WIDTH = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DST_HEIGHT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CHANNELS = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_LINEAR = 3'd5;

   typedef struct packed {
      logic we;
      logic [ADDR_W-1:0] addr;
      logic [PIX_W-1:0] data;
   } wr_type;

   typedef struct packed {
      logic valid;
      op_type op;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [PIX_W-1:0] pixel;
   } side_type;

   typedef struct packed {
      logic valid;
      op_type op;
      logic linear;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [W_W-1:0] wx0;
      logic [W_W-1:0] wx1;
      logic [W_W-1:0] wy0;
      logic [W_W-1:0] wy1;
   } rd_side_type;

   typedef struct packed {
      logic valid;
      op_type op;
      logic linear;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [PIX_W-1:0] p00;
   } lane_side_type;

   // zero reads as one, larger values saturate
   function automatic logic [SZ_W-1:0] lim_src(logic [SRC_CFG_W-1:0] v, int hi);
      logic [SZ_W-1:0] r;
      if (v == '0) r = SZ_W'(1);
      else if (int'(v) > hi) r = SZ_W'(hi);
      else r = SZ_W'(v);
      return r;
   endfunction

   function automatic logic [DST_W-1:0] lim_dst(logic [DST_W-1:0] v);
      logic [DST_W-1:0] r;
      if (v == '0) r = DST_W'(1);
      else if (int'(v) > DST_LIMIT) r = DST_W'(DST_LIMIT);
      else r = v;
      return r;
   endfunction

   function automatic logic [CNT_W-1:0] lim_cnt(logic [CNT_W-1:0] v);
      logic [CNT_W-1:0] r;
      if (v == '0) r = CNT_W'(1);
      else if (int'(v) > LANES) r = CNT_W'(LANES);
      else r = v;
      return r;
   endfunction

   function automatic logic [ADDR_W-1:0] mk_addr(int x, int y);
      return ADDR_W'(y * MAX_SRC_WIDTH + x);
   endfunction

endpackage

@@ sv/image_resampler_bilinear_wrap.sv @@
// Top level of the bilinear image resampler: config registers, position lanes,
// source store, channel lanes, merge and output skid. Depends on irbw_pkg,
// irbw_locate, irbw_store and irbw_lane.
//
// Usage:
//  - req channel (valid/ready): op LOAD writes req_pixel_in into the source
//    store at (coord_x, coord_y); op REQUEST asks for destination pixel
//    (coord_x, coord_y). Loads beyond the store are dropped.
//  - rsp channel (valid/ready): one beat per REQUEST, in request order,
//    carrying the resampled pixel and its destination coordinates.
//    Loads give no beat.
//  - csr port: write-only; csr_we with csr_index and csr_wdata. Write only
//    while the block is idle.
//  - Throughput: one beat per cycle while the output skid is not full, fully
//    pipelined. Position math is a bit-per-stage divide and modulo per axis;
//    the store is two copies with two read ports each, so the 2x2 neighbours
//    are read together in the same cycle. Pipeline: 59 position stages, 1 store
//    read, 4 blend stages and the output register lie before rsp_valid rises.
//  - Reset: synchronous, clears pipeline valids, output valid, skid and config to
//    defaults. The source store is not cleared; read only loaded pixels.
//  - Stall: a two-entry output (register plus skid) absorbs a stalled
//    receiver; once the skid fills, req_ready drops and the pipe freezes.
module image_resampler_bilinear_wrap (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_op,
   input  logic [irbw_pkg::COORD_W-1:0]        req_coord_x,
   input  logic [irbw_pkg::COORD_W-1:0]        req_coord_y,
   input  logic [irbw_pkg::PIX_W-1:0]          req_pixel_in,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [irbw_pkg::PIX_W-1:0]          rsp_pixel_out,
   output logic [irbw_pkg::COORD_W-1:0]        rsp_out_x,
   output logic [irbw_pkg::COORD_W-1:0]        rsp_out_y,
   input  logic                                csr_we,
   input  logic [irbw_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [irbw_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   localparam int LL = irbw_pkg::LOC_LAT;
   localparam int LN = irbw_pkg::LANE_LAT;
   localparam int SZ_W = irbw_pkg::SZ_W;
   localparam int CH_W = irbw_pkg::CH_W;
   localparam int PIX_W = irbw_pkg::PIX_W;
   localparam int W_W = irbw_pkg::W_W;

   // ---------------- configuration registers ----------------
   logic [irbw_pkg::SRC_CFG_W-1:0] src_width_ff, src_height_ff;
   logic [irbw_pkg::DST_W-1:0]     dst_width_ff, dst_height_ff;
   logic [irbw_pkg::CNT_W-1:0]     channel_count_ff;
   logic                           linear_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         src_width_ff <= irbw_pkg::SRC_CFG_W'(1);
         src_height_ff <= irbw_pkg::SRC_CFG_W'(1);
         dst_width_ff <= irbw_pkg::DST_W'(1);
         dst_height_ff <= irbw_pkg::DST_W'(1);
         channel_count_ff <= irbw_pkg::CNT_W'(3);
         linear_mode_ff <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            irbw_pkg::CSR_SRC_WIDTH:  src_width_ff <= csr_wdata[irbw_pkg::SRC_CFG_W-1:0];
            irbw_pkg::CSR_SRC_HEIGHT: src_height_ff <= csr_wdata[irbw_pkg::SRC_CFG_W-1:0];
            irbw_pkg::CSR_DST_WIDTH:  dst_width_ff <= csr_wdata[irbw_pkg::DST_W-1:0];
            irbw_pkg::CSR_DST_HEIGHT: dst_height_ff <= csr_wdata[irbw_pkg::DST_W-1:0];
            irbw_pkg::CSR_CHANNELS:   channel_count_ff <= csr_wdata[irbw_pkg::CNT_W-1:0];
            irbw_pkg::CSR_LINEAR:     linear_mode_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // effective sizes: zero acts as one, oversize saturates
   logic [SZ_W-1:0]                sw, sh;
   logic [irbw_pkg::DST_W-1:0]     dw, dh;
   logic [irbw_pkg::CNT_W-1:0]     nch;

   assign sw = irbw_pkg::lim_src(src_width_ff, irbw_pkg::MAX_SRC_WIDTH);
   assign sh = irbw_pkg::lim_src(src_height_ff, irbw_pkg::MAX_SRC_HEIGHT);
   assign dw = irbw_pkg::lim_dst(dst_width_ff);
   assign dh = irbw_pkg::lim_dst(dst_height_ff);
   assign nch = irbw_pkg::lim_cnt(channel_count_ff);

   // ---------------- pipeline advance ----------------
   // The whole pipe moves together; it only halts with the skid full.
   logic adv;
   logic rsp_valid_ff, skid_valid_ff;

   assign adv = !skid_valid_ff;
   assign req_ready = adv;

   // ---------------- position stage (both axes) ----------------
   irbw_pkg::side_type side_ff [LL];
   logic [SZ_W-1:0]                 xi, yi;
   logic [irbw_pkg::FRAC_BITS-1:0]  xf, yf;

   irbw_locate u_loc_x (
      .clock    (clock),
      .en       (adv),
      .coord    (req_coord_x),
      .src_size (sw),
      .dst_size (dw),
      .idx      (xi),
      .frac     (xf)
   );

   irbw_locate u_loc_y (
      .clock    (clock),
      .en       (adv),
      .coord    (req_coord_y),
      .src_size (sh),
      .dst_size (dh),
      .idx      (yi),
      .frac     (yf)
   );

   // beat sidecar runs alongside the position lanes
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LL; i++) begin
            side_ff[i] <= '0;
         end
      end else if (adv) begin
         side_ff[0].valid <= req_valid;
         side_ff[0].op <= irbw_pkg::op_type'(req_op);
         side_ff[0].x <= req_coord_x;
         side_ff[0].y <= req_coord_y;
         side_ff[0].pixel <= req_pixel_in;
         for (int i = 1; i < LL; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   // ---------------- store access ----------------
   irbw_pkg::side_type              loc;
   logic [SZ_W:0]                   xp1, yp1;
   logic [SZ_W-1:0]                 x1, y1;
   logic                            load_in_range;
   irbw_pkg::wr_type                wr;
   logic [irbw_pkg::ADDR_W-1:0]     raddr [irbw_pkg::TAPS];
   logic [PIX_W-1:0]                rdata [irbw_pkg::TAPS];

   assign loc = side_ff[LL-1];
   // right and lower neighbours wrap to column and row zero
   assign xp1 = {1'b0, xi} + (SZ_W+1)'(1);
   assign yp1 = {1'b0, yi} + (SZ_W+1)'(1);
   assign x1 = (xp1 == {1'b0, sw}) ? '0 : xp1[SZ_W-1:0];
   assign y1 = (yp1 == {1'b0, sh}) ? '0 : yp1[SZ_W-1:0];

   assign load_in_range = (int'(loc.x) < irbw_pkg::MAX_SRC_WIDTH) &&
                          (int'(loc.y) < irbw_pkg::MAX_SRC_HEIGHT);
   assign wr.we = adv && loc.valid && (loc.op == irbw_pkg::OP_LOAD) && load_in_range;
   assign wr.addr = irbw_pkg::mk_addr(int'(loc.x), int'(loc.y));
   assign wr.data = loc.pixel;

   assign raddr[0] = irbw_pkg::mk_addr(int'(xi), int'(yi));
   assign raddr[1] = irbw_pkg::mk_addr(int'(x1), int'(yi));
   assign raddr[2] = irbw_pkg::mk_addr(int'(xi), int'(y1));
   assign raddr[3] = irbw_pkg::mk_addr(int'(x1), int'(y1));

   irbw_store u_store (
      .clock (clock),
      .en    (adv),
      .wr    (wr),
      .raddr (raddr),
      .rdata (rdata)
   );

   // sidecar for the read cycle, with weights
   irbw_pkg::rd_side_type rd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff <= '0;
      end else if (adv) begin
         rd_ff.valid <= loc.valid;
         rd_ff.op <= loc.op;
         rd_ff.linear <= linear_mode_ff;
         rd_ff.x <= loc.x;
         rd_ff.y <= loc.y;
         rd_ff.wx0 <= irbw_pkg::FIX_ONE - W_W'(xf);
         rd_ff.wx1 <= W_W'(xf);
         rd_ff.wy0 <= irbw_pkg::FIX_ONE - W_W'(yf);
         rd_ff.wy1 <= W_W'(yf);
      end
   end

   // ---------------- channel lanes ----------------
   logic [CH_W-1:0] lane_val [irbw_pkg::LANES];

   for (genvar k = 0; k < irbw_pkg::LANES; k++) begin : g_lane
      irbw_lane u_lane (
         .clock (clock),
         .en    (adv),
         .pa    (rdata[0][k*CH_W +: CH_W]),
         .pb    (rdata[1][k*CH_W +: CH_W]),
         .pc    (rdata[2][k*CH_W +: CH_W]),
         .pd    (rdata[3][k*CH_W +: CH_W]),
         .wx0   (rd_ff.wx0),
         .wx1   (rd_ff.wx1),
         .wy0   (rd_ff.wy0),
         .wy1   (rd_ff.wy1),
         .value (lane_val[k])
      );
   end

   irbw_pkg::lane_side_type lane_ff [LN];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LN; i++) begin
            lane_ff[i] <= '0;
         end
      end else if (adv) begin
         lane_ff[0].valid <= rd_ff.valid;
         lane_ff[0].op <= rd_ff.op;
         lane_ff[0].linear <= rd_ff.linear;
         lane_ff[0].x <= rd_ff.x;
         lane_ff[0].y <= rd_ff.y;
         lane_ff[0].p00 <= rdata[0];
         for (int i = 1; i < LN; i++) begin
            lane_ff[i] <= lane_ff[i-1];
         end
      end
   end

   // ---------------- merge ----------------
   // active channels take the blend or the nearest pixel, the rest are zero
   irbw_pkg::lane_side_type fin;
   logic [PIX_W-1:0]        merged;

   assign fin = lane_ff[LN-1];

   always_comb begin
      merged = '0;
      for (int k = 0; k < irbw_pkg::LANES; k++) begin
         if (k < int'(nch)) begin
            merged[k*CH_W +: CH_W] = fin.linear ? lane_val[k] : fin.p00[k*CH_W +: CH_W];
         end
      end
   end

   // ---------------- output register and skid ----------------
   logic [PIX_W-1:0]               out_pix_ff, skid_pix_ff;
   logic [irbw_pkg::COORD_W-1:0]   out_x_ff, out_y_ff, skid_x_ff, skid_y_ff;
   logic                           push, take;

   assign push = adv && fin.valid && (fin.op == irbw_pkg::OP_REQUEST);
   assign take = rsp_valid_ff && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (take) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (push) begin
         if (!rsp_valid_ff || take) begin
            rsp_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (take) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (take) begin
            out_pix_ff <= skid_pix_ff;
            out_x_ff <= skid_x_ff;
            out_y_ff <= skid_y_ff;
         end
      end else if (push) begin
         if (!rsp_valid_ff || take) begin
            out_pix_ff <= merged;
            out_x_ff <= fin.x;
            out_y_ff <= fin.y;
         end else begin
            skid_pix_ff <= merged;
            skid_x_ff <= fin.x;
            skid_y_ff <= fin.y;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_pixel_out = out_pix_ff;
   assign rsp_out_x = out_x_ff;
   assign rsp_out_y = out_y_ff;

   // ---------------- assertions ----------------
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid holds a beat while output register is empty");

   a_empty_no_skid: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |=> !skid_valid_ff)
      else $error("skid filled although output register was free");

   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      (adv && fin.valid && fin.op == irbw_pkg::OP_LOAD && !rsp_valid_ff) |=> !rsp_valid_ff)
      else $error("load beat produced a response");

endmodule

@@ sv/irbw_locate.sv @@
// One axis of source position: coord*src/dst as wrapped index plus fraction.
// Multiply, then a restoring divide and a restoring modulo, one bit per stage.
// Depends on irbw_pkg.
module irbw_locate (
   input  logic                           clock,
   input  logic                           en,
   input  logic [irbw_pkg::COORD_W-1:0]   coord,
   input  logic [irbw_pkg::SZ_W-1:0]      src_size,
   input  logic [irbw_pkg::DST_W-1:0]     dst_size,
   output logic [irbw_pkg::SZ_W-1:0]      idx,
   output logic [irbw_pkg::FRAC_BITS-1:0] frac
);
   localparam int P_W = irbw_pkg::P_W;
   localparam int N_W = irbw_pkg::N_W;
   localparam int F = irbw_pkg::FRAC_BITS;
   localparam int SZ_W = irbw_pkg::SZ_W;
   localparam int DST_W = irbw_pkg::DST_W;

   logic [P_W-1:0]   prod_ff;
   logic [N_W-1:0]   dq_ff [N_W];
   logic [DST_W-1:0] dr_ff [N_W-1];
   logic [P_W-1:0]   mq_ff [P_W-1];
   logic [SZ_W-1:0]  mr_ff [P_W];
   logic [F-1:0]     mf_ff [P_W];

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= P_W'(coord) * P_W'(src_size);
      end
   end

   // quotient of (prod << F) / dst_size; remainder stays below dst_size
   for (genvar i = 0; i < N_W; i++) begin : g_div
      logic [N_W-1:0]   q_cur;
      logic [DST_W-1:0] r_cur;
      logic [DST_W:0]   trial;
      logic             ge;
      if (i == 0) begin : g_first
         assign q_cur = {prod_ff, {F{1'b0}}};
         assign r_cur = '0;
      end else begin : g_next
         assign q_cur = dq_ff[i-1];
         assign r_cur = dr_ff[i-1];
      end
      assign trial = {r_cur, q_cur[N_W-1]};
      assign ge = trial >= {1'b0, dst_size};
      always_ff @(posedge clock) begin
         if (en) begin
            dq_ff[i] <= {q_cur[N_W-2:0], ge};
         end
      end
      if (i < N_W - 1) begin : g_rem
         always_ff @(posedge clock) begin
            if (en) begin
               dr_ff[i] <= ge ? DST_W'(trial - {1'b0, dst_size}) : DST_W'(trial);
            end
         end
      end
   end

   // integer part modulo src_size; fraction rides along
   for (genvar i = 0; i < P_W; i++) begin : g_mod
      logic [P_W-1:0]  q_cur;
      logic [SZ_W-1:0] r_cur;
      logic [F-1:0]    f_cur;
      logic [SZ_W:0]   trial;
      logic            ge;
      if (i == 0) begin : g_first
         assign q_cur = dq_ff[N_W-1][N_W-1:F];
         assign r_cur = '0;
         assign f_cur = dq_ff[N_W-1][F-1:0];
      end else begin : g_next
         assign q_cur = mq_ff[i-1];
         assign r_cur = mr_ff[i-1];
         assign f_cur = mf_ff[i-1];
      end
      assign trial = {r_cur, q_cur[P_W-1]};
      assign ge = trial >= {1'b0, src_size};
      always_ff @(posedge clock) begin
         if (en) begin
            mr_ff[i] <= ge ? SZ_W'(trial - {1'b0, src_size}) : SZ_W'(trial);
            mf_ff[i] <= f_cur;
         end
      end
      if (i < P_W - 1) begin : g_shift
         always_ff @(posedge clock) begin
            if (en) begin
               mq_ff[i] <= {q_cur[P_W-2:0], 1'b0};
            end
         end
      end
   end

   assign idx = mr_ff[P_W-1];
   assign frac = mf_ff[P_W-1];

endmodule

@@ sv/irbw_store.sv @@
// Source pixel store: two copies, each one write port and two registered reads,
// so all four 2x2 neighbours come out together in the same cycle. Depends on irbw_pkg.
module irbw_store (
   input  logic                          clock,
   input  logic                          en,
   input  irbw_pkg::wr_type              wr,
   input  logic [irbw_pkg::ADDR_W-1:0]   raddr [irbw_pkg::TAPS],
   output logic [irbw_pkg::PIX_W-1:0]    rdata [irbw_pkg::TAPS]
);
   logic [irbw_pkg::PIX_W-1:0] mem_a [irbw_pkg::DEPTH];
   logic [irbw_pkg::PIX_W-1:0] mem_b [irbw_pkg::DEPTH];

   always_ff @(posedge clock) begin
      if (wr.we) begin
         mem_a[wr.addr] <= wr.data;
      end
      if (en) begin
         rdata[0] <= mem_a[raddr[0]];
         rdata[1] <= mem_a[raddr[1]];
      end
   end

   always_ff @(posedge clock) begin
      if (wr.we) begin
         mem_b[wr.addr] <= wr.data;
      end
      if (en) begin
         rdata[2] <= mem_b[raddr[2]];
         rdata[3] <= mem_b[raddr[3]];
      end
   end

endmodule

@@ sv/irbw_lane.sv @@
// One channel lane of the bilinear blend: horizontal then vertical weighting,
// truncate and clamp. Four stages. Depends on irbw_pkg.
module irbw_lane (
   input  logic                       clock,
   input  logic                       en,
   input  logic [irbw_pkg::CH_W-1:0]  pa,
   input  logic [irbw_pkg::CH_W-1:0]  pb,
   input  logic [irbw_pkg::CH_W-1:0]  pc,
   input  logic [irbw_pkg::CH_W-1:0]  pd,
   input  logic [irbw_pkg::W_W-1:0]   wx0,
   input  logic [irbw_pkg::W_W-1:0]   wx1,
   input  logic [irbw_pkg::W_W-1:0]   wy0,
   input  logic [irbw_pkg::W_W-1:0]   wy1,
   output logic [irbw_pkg::CH_W-1:0]  value
);
   localparam int CH_W = irbw_pkg::CH_W;
   localparam int W_W = irbw_pkg::W_W;
   localparam int M_W = CH_W + W_W;
   localparam int H_W = M_W + 1;
   localparam int V_W = H_W + W_W;
   localparam int S_W = V_W + 1;
   localparam logic [S_W-1:0] CH_MAX = S_W'((1 << CH_W) - 1);

   logic [M_W-1:0] ma_ff, mb_ff, mc_ff, md_ff;
   logic [W_W-1:0] wy0_s1_ff, wy1_s1_ff, wy0_s2_ff, wy1_s2_ff;
   logic [H_W-1:0] h0_ff, h1_ff;
   logic [V_W-1:0] v0_ff, v1_ff;
   logic [S_W-1:0] sum;
   logic [S_W-1:0] shifted;

   assign sum = S_W'(v0_ff) + S_W'(v1_ff);
   assign shifted = sum >> (2 * irbw_pkg::FRAC_BITS);

   always_ff @(posedge clock) begin
      if (en) begin
         ma_ff <= M_W'(pa) * M_W'(wx0);
         mb_ff <= M_W'(pb) * M_W'(wx1);
         mc_ff <= M_W'(pc) * M_W'(wx0);
         md_ff <= M_W'(pd) * M_W'(wx1);
         wy0_s1_ff <= wy0;
         wy1_s1_ff <= wy1;
         h0_ff <= H_W'(ma_ff) + H_W'(mb_ff);
         h1_ff <= H_W'(mc_ff) + H_W'(md_ff);
         wy0_s2_ff <= wy0_s1_ff;
         wy1_s2_ff <= wy1_s1_ff;
         v0_ff <= V_W'(h0_ff) * V_W'(wy0_s2_ff);
         v1_ff <= V_W'(h1_ff) * V_W'(wy1_s2_ff);
         value <= (shifted > CH_MAX) ? CH_W'(CH_MAX) : CH_W'(shifted);
      end
   end

endmodule

@@ bench/image_resampler_bilinear_wrap_tb.sv @@
// Self-checking bench for image_resampler_bilinear_wrap: random load/request beats,
// random valid/ready gaps, predicted pixels compared in order. Depends on irbw_pkg.
`timescale 1ns / 1ps

module image_resampler_bilinear_wrap_tb;
   localparam int PIX_W = irbw_pkg::PIX_W;
   localparam int COORD_W = irbw_pkg::COORD_W;
   localparam int CSR_IDX_W = irbw_pkg::CSR_IDX_W;
   localparam int CSR_DATA_W = irbw_pkg::CSR_DATA_W;
   localparam int MAX_SRC_WIDTH = irbw_pkg::MAX_SRC_WIDTH;
   localparam int MAX_SRC_HEIGHT = irbw_pkg::MAX_SRC_HEIGHT;
   localparam int FRAC_BITS = irbw_pkg::FRAC_BITS;

   typedef struct {
      logic [PIX_W-1:0] pix;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
   } pixel_beat_type;

   // Scoreboard: mirrors the source store and config, predicts each requested pixel.
   class resample_scoreboard;
      logic [PIX_W-1:0] src_pix[int];   // entry present = loaded
      int unsigned cfg[6];
      pixel_beat_type pending[$];
      int errors;

      function new();
         cfg = '{1, 1, 1, 1, 3, 0};
         errors = 0;
      endfunction

      function int unsigned clip(int unsigned v, int unsigned hi);
         if (v == 0) return 1;
         return (v > hi) ? hi : v;
      endfunction

      function int unsigned eff(logic [CSR_IDX_W-1:0] idx);
         case (idx)
            irbw_pkg::CSR_SRC_WIDTH:  return clip(cfg[idx], irbw_pkg::MAX_SRC_WIDTH);
            irbw_pkg::CSR_SRC_HEIGHT: return clip(cfg[idx], irbw_pkg::MAX_SRC_HEIGHT);
            irbw_pkg::CSR_DST_WIDTH:  return clip(cfg[idx], irbw_pkg::DST_LIMIT);
            irbw_pkg::CSR_DST_HEIGHT: return clip(cfg[idx], irbw_pkg::DST_LIMIT);
            irbw_pkg::CSR_CHANNELS:   return clip(cfg[idx], irbw_pkg::LANES);
            default:                  return cfg[idx];
         endcase
      endfunction

      // exact source position: wrapped integer index plus truncated fraction
      function void locate(input longint unsigned d, s, dn,
                           output longint unsigned idx, output longint unsigned frac);
         longint unsigned p;
         p = d * s;
         idx = (p / dn) % s;
         frac = ((p % dn) << FRAC_BITS) / dn;
      endfunction

      function void taps(input int x, input int y, output int tx[4], output int ty[4]);
         longint unsigned xi, xf, yi, yf;
         locate(x, eff(irbw_pkg::CSR_SRC_WIDTH), eff(irbw_pkg::CSR_DST_WIDTH), xi, xf);
         locate(y, eff(irbw_pkg::CSR_SRC_HEIGHT), eff(irbw_pkg::CSR_DST_HEIGHT), yi, yf);
         tx = '{int'(xi), int'((xi + 1) % eff(irbw_pkg::CSR_SRC_WIDTH)), int'(xi),
                int'((xi + 1) % eff(irbw_pkg::CSR_SRC_WIDTH))};
         ty = '{int'(yi), int'(yi), int'((yi + 1) % eff(irbw_pkg::CSR_SRC_HEIGHT)),
                int'((yi + 1) % eff(irbw_pkg::CSR_SRC_HEIGHT))};
      endfunction

      function logic [PIX_W-1:0] resample(int x, int y);
         longint unsigned xi, xf, yi, yf, w[4], sum;
         int tx[4], ty[4];
         logic [PIX_W-1:0] p[4];
         logic [PIX_W-1:0] r;
         r = '0;
         locate(x, eff(irbw_pkg::CSR_SRC_WIDTH), eff(irbw_pkg::CSR_DST_WIDTH), xi, xf);
         locate(y, eff(irbw_pkg::CSR_SRC_HEIGHT), eff(irbw_pkg::CSR_DST_HEIGHT), yi, yf);
         taps(x, y, tx, ty);
         for (int i = 0; i < 4; i++) p[i] = src_pix[ty[i] * MAX_SRC_WIDTH + tx[i]];
         w[0] = (64'd1 << FRAC_BITS) - xf;   // x weights
         w[1] = xf;
         w[2] = (64'd1 << FRAC_BITS) - yf;   // y weights
         w[3] = yf;
         for (int k = 0; k < eff(irbw_pkg::CSR_CHANNELS); k++) begin
            if (cfg[irbw_pkg::CSR_LINEAR] == 0) begin
               r[8*k +: 8] = p[0][8*k +: 8];
            end else begin
               sum = p[0][8*k +: 8] * w[0] * w[2] + p[1][8*k +: 8] * w[1] * w[2]
                   + p[2][8*k +: 8] * w[0] * w[3] + p[3][8*k +: 8] * w[1] * w[3];
               sum = sum >> (2 * FRAC_BITS);
               r[8*k +: 8] = (sum > 255) ? 8'hFF : sum[7:0];
            end
         end
         return r;
      endfunction

      function void note_beat(irbw_pkg::op_type op, int x, int y, logic [PIX_W-1:0] pix);
         pixel_beat_type b;
         if (op == irbw_pkg::OP_LOAD) begin
            if (x < MAX_SRC_WIDTH && y < MAX_SRC_HEIGHT) src_pix[y * MAX_SRC_WIDTH + x] = pix;
         end else begin
            b.pix = resample(x, y);
            b.x = COORD_W'(x);
            b.y = COORD_W'(y);
            pending.push_back(b);
         end
      endfunction

      function void check_beat(logic [PIX_W-1:0] pix, logic [COORD_W-1:0] x,
                               logic [COORD_W-1:0] y);
         pixel_beat_type b;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected rsp beat pix=%h x=%0d y=%0d", pix, x, y);
            return;
         end
         b = pending.pop_front();
         if (b.pix !== pix || b.x !== x || b.y !== y) begin
            errors++;
            if (errors <= 10)
               $display("rsp mismatch: exp pix=%h x=%0d y=%0d, got pix=%h x=%0d y=%0d",
                        b.pix, b.x, b.y, pix, x, y);
         end
      endfunction
   endclass

   localparam int DRAIN_CYCLES = 80;     // longer than the pipe latency
   localparam int WATCHDOG_LIMIT = 5000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_op = 1'b0;
   logic [COORD_W-1:0] req_coord_x = '0;
   logic [COORD_W-1:0] req_coord_y = '0;
   logic [PIX_W-1:0] req_pixel_in = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [PIX_W-1:0] rsp_pixel_out;
   logic [COORD_W-1:0] rsp_out_x;
   logic [COORD_W-1:0] rsp_out_y;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   resample_scoreboard sb = new();
   bit gaps_on = 1'b1;     // random gaps on both sides
   int quiet_cycles = 0;

   image_resampler_bilinear_wrap u_top (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // rsp side: check every beat, throttle ready ~38% of cycles when gaps are on
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_beat(rsp_pixel_out, rsp_out_x, rsp_out_y);
      rsp_ready <= !gaps_on || ($urandom_range(99) >= 38);
   end

   // watchdog: too long with no beat on either channel ends the run
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // One req beat. Called right after a rising edge; returns at the accepting edge
   // with valid still high so back-to-back beats never toggle it within a step.
   task automatic send_beat(irbw_pkg::op_type op, int x, int y, logic [PIX_W-1:0] pix);
      while (gaps_on && $urandom_range(99) < 38) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_coord_x <= COORD_W'(x);
      req_coord_y <= COORD_W'(y);
      req_pixel_in <= pix;
      do @(posedge clock); while (!req_ready);
      sb.note_beat(op, x, y, pix);
   endtask

   // a request, preceded by loads of any neighbour not yet in the store
   task automatic send_request(int x, int y);
      int tx[4], ty[4];
      sb.taps(x, y, tx, ty);
      for (int i = 0; i < 4; i++)
         if (!sb.src_pix.exists(ty[i] * MAX_SRC_WIDTH + tx[i]))
            send_beat(irbw_pkg::OP_LOAD, tx[i], ty[i], $urandom());
      send_beat(irbw_pkg::OP_REQUEST, x, y, $urandom());
   endtask

   // drop valid, wait out all expected beats plus the pipe depth
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // write all six registers; block must be idle
   task automatic set_config(int sw, int sh, int dw, int dh, int nch, int lin);
      int vals[6];
      vals = '{sw, sh, dw, dh, nch, lin};
      for (int i = 0; i < 6; i++) begin
         csr_we <= 1'b1;
         csr_index <= CSR_IDX_W'(i);
         csr_wdata <= CSR_DATA_W'(vals[i]);
         @(posedge clock);
         sb.cfg[i] = (i == irbw_pkg::CSR_SRC_WIDTH || i == irbw_pkg::CSR_SRC_HEIGHT)
                   ? (vals[i] & 'h1FF)
                   : (i == irbw_pkg::CSR_DST_WIDTH || i == irbw_pkg::CSR_DST_HEIGHT)
                   ? (vals[i] & 'h1FFF)
                   : (i == irbw_pkg::CSR_CHANNELS) ? (vals[i] & 'h7) : (vals[i] & 'h1);
      end
      csr_we <= 1'b0;
   endtask

   // Random mix: mostly in-frame requests, some requests anywhere in the 12-bit
   // space, some loads (in-store rewrites and out-of-store drops).
   task automatic run_random(int n, bit mid_pause);
      int r;
      for (int i = 0; i < n; i++) begin
         if (mid_pause && i == n / 2) drain();
         r = $urandom_range(99);
         if (r < 6)
            send_beat(irbw_pkg::OP_LOAD, $urandom_range(4095), $urandom_range(4095),
                      $urandom());
         else if (r < 12)
            send_beat(irbw_pkg::OP_LOAD, $urandom_range(sb.eff(irbw_pkg::CSR_SRC_WIDTH) - 1),
                      $urandom_range(sb.eff(irbw_pkg::CSR_SRC_HEIGHT) - 1), $urandom());
         else if (r < 22)
            send_request($urandom_range(4095), $urandom_range(4095));
         else
            send_request($urandom_range(sb.eff(irbw_pkg::CSR_DST_WIDTH) - 1),
                         $urandom_range(sb.eff(irbw_pkg::CSR_DST_HEIGHT) - 1));
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset config, store-edge loads, drops beyond the store
      send_beat(irbw_pkg::OP_LOAD, 0, 0, 32'hFFFF_FFFF);
      send_beat(irbw_pkg::OP_LOAD, MAX_SRC_WIDTH, 0, 32'h1234_5678);
      send_beat(irbw_pkg::OP_LOAD, 0, 4095, 32'h0);
      send_beat(irbw_pkg::OP_LOAD, 255, 255, 32'h0000_0000);
      send_request(0, 0);
      send_request(4095, 4095);
      send_request(0, 4095);
      drain();

      // linear, all four channels, wrap at right and bottom
      set_config(4, 3, 8, 6, 4, 1);
      send_beat(irbw_pkg::OP_LOAD, 3, 2, 32'hFFFF_FFFF);
      send_beat(irbw_pkg::OP_LOAD, 0, 0, 32'h0000_0000);
      send_request(7, 5);
      send_request(0, 0);
      send_request(4095, 4095);
      drain();

      // zeros read as one
      set_config(0, 0, 0, 0, 0, 1);
      send_request(0, 0);
      send_request(4095, 0);
      drain();

      // oversized registers saturate
      set_config(511, 2, 8191, 8191, 7, 1);
      send_request(4095, 4095);
      send_request(1, 1);
      drain();

      // full-size nearest, then linear; no gaps on the first
      gaps_on = 1'b0;
      set_config(256, 256, 4096, 4096, 4, 0);
      run_random(40, 1'b0);
      drain();
      gaps_on = 1'b1;
      set_config(256, 256, 4096, 4096, 2, 1);
      run_random(40, 1'b1);
      drain();

      // small random geometries
      for (int ph = 0; ph < 12; ph++) begin
         set_config($urandom_range(16), $urandom_range(16), $urandom_range(64),
                    $urandom_range(64), $urandom_range(7), $urandom_range(1));
         run_random(55, ph == 3);
         drain();
      end

      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
